// ===== rtl/rotation_affine_matrix_core_macros.svh =====
// Assertion macros for the rotation affine matrix core.
// Uses the including module's aclk and aresetn; no other dependencies.
`ifndef ROTATION_AFFINE_MATRIX_CORE_MACROS_SVH
`define ROTATION_AFFINE_MATRIX_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define RAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define RAM_ASSERT_NEVER(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(prop)) else $error(msg);
`else
`define RAM_ASSERT(label, prop, msg)
`define RAM_ASSERT_NEVER(label, prop, msg)
`endif

`endif

// ===== rtl/rotaff_pkg.sv =====
// Shared types, widths, angle constants and the CORDIC arctangent table.
// No dependencies; used by rotaff_cordic_stage and rotation_affine_matrix_core.
`default_nettype none

package rotaff_pkg;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;

    // Field widths
    localparam int CTR_W   = 16;
    localparam int ANG_W   = 17;
    localparam int SCL_W   = 16;
    localparam int COEF_W  = 17;
    localparam int OFF_W   = 34;

    // Internal widths
    localparam int AW = 18;                 // reduced angle, 1/128 degree
    localparam int XW = 34;                 // CORDIC x/y, Q30
    localparam int ZW = 34;                 // CORDIC z, 2^-24 degree
    localparam int TW = 32;                 // trig operand into the multiplier
    localparam int PW = SCL_W + 1 + TW;     // scale * trig product
    localparam int TABLE_LEN = 24;
    localparam int Z_SHIFT = 17;            // 1/128 degree -> 2^-24 degree

    localparam logic signed [AW-1:0] FULL_TURN        = 18'sd46080;
    localparam logic signed [AW-1:0] HALF_TURN        = 18'sd23040;
    localparam logic signed [AW-1:0] NEG_HALF_TURN    = -18'sd23040;
    localparam logic signed [AW-1:0] QUARTER_TURN     = 18'sd11520;
    localparam logic signed [AW-1:0] NEG_QUARTER_TURN = -18'sd11520;

    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic signed [XW-1:0]    x;
        logic signed [XW-1:0]    y;
        logic signed [ZW-1:0]    z;
        logic                    flip;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic [SCL_W-1:0]        scale;
    } cordic_vec_t;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 34'sd754974720;
            5'd1:    v = 34'sd445687602;
            5'd2:    v = 34'sd235489088;
            5'd3:    v = 34'sd119537938;
            5'd4:    v = 34'sd60000934;
            5'd5:    v = 34'sd30029717;
            5'd6:    v = 34'sd15018523;
            5'd7:    v = 34'sd7509720;
            5'd8:    v = 34'sd3754917;
            5'd9:    v = 34'sd1877466;
            5'd10:   v = 34'sd938734;
            5'd11:   v = 34'sd469367;
            5'd12:   v = 34'sd234684;
            5'd13:   v = 34'sd117342;
            5'd14:   v = 34'sd58671;
            5'd15:   v = 34'sd29335;
            5'd16:   v = 34'sd14668;
            5'd17:   v = 34'sd7334;
            5'd18:   v = 34'sd3667;
            5'd19:   v = 34'sd1833;
            5'd20:   v = 34'sd917;
            5'd21:   v = 34'sd458;
            5'd22:   v = 34'sd229;
            5'd23:   v = 34'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rotaff_cordic_stage.sv =====
// One registered rotation-mode CORDIC micro-rotation.
// Depends on rotaff_pkg (cordic_vec_t, atan_entry).
`default_nettype none

module rotaff_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  rotaff_pkg::cordic_vec_t in_vec,
    output logic                    out_valid,
    output rotaff_pkg::cordic_vec_t out_vec
);
    import rotaff_pkg::*;

    logic signed [XW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in, atan_i;
    cordic_vec_t          vec_next, vec_reg;
    logic                 valid_reg;

    always_comb begin
        x_in   = in_vec.x;
        y_in   = in_vec.y;
        z_in   = in_vec.z;
        dx     = y_in >>> STAGE;
        dy     = x_in >>> STAGE;
        atan_i = atan_entry(5'(STAGE));
        vec_next = in_vec;
        // z >= 0 rotates forward
        if (!z_in[ZW-1]) begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = z_in - atan_i;
        end else begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = z_in + atan_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

// ===== rtl/rotation_affine_matrix_core.sv =====
// Top level: 2x3 rotation-with-scale affine matrix about a center, fixed point.
// Depends on rotaff_pkg, rotaff_cordic_stage and rotation_affine_matrix_core_macros.svh.
//
//  channel | dir | handshake          | payload (low bit up)
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | center_x, center_y, angle_deg, scale_factor
//  m_      | out | m_tvalid/m_tready  | alpha, beta, offset_x, offset_y
//
// One transfer per cycle in each direction, sustained while m_tready keeps the skid entry empty.
// Path from input transfer to m_tvalid: stage 0, the unrolled CORDIC (N = min(CORDIC_STAGES, 24),
// one register per micro-rotation), stages M, R, Q, P, O and the output register.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
// A two-entry output (register plus skid) decouples the sides; the pipeline
// freezes, losing nothing, only while the skid entry is occupied.
`default_nettype none
`include "rotation_affine_matrix_core_macros.svh"

module rotation_affine_matrix_core #(
    parameter int CORDIC_STAGES  = 16,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // center_x[15:0], center_y[31:16], angle_deg[48:32], scale_factor[64:49], zero pad
    input  logic [rotaff_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // alpha[16:0], beta[33:17], offset_x[67:34], offset_y[101:68], zero pad
    output logic [rotaff_pkg::M_TDATA_W-1:0] m_tdata
);
    import rotaff_pkg::*;

    localparam int N_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int RSH      = 42 - COEF_FRAC_BITS;   // Q30 * Q12 -> Q.F
    localparam int CW       = COEF_FRAC_BITS + 6;    // internal coefficient width
    localparam int PRW      = CW + 1 + CTR_W;        // offset partial product width
    localparam int SUMW     = (PRW + 1 > OFF_W) ? PRW + 1 : OFF_W;
    localparam logic [PW-1:0]       RND_HALF = {{(PW-1){1'b0}}, 1'b1} << (RSH - 1);
    localparam logic signed [CW:0]  COEF_ONE = {{CW{1'b0}}, 1'b1} <<< COEF_FRAC_BITS;

    // ---------------------------------------------------------------
    // Global advance: the whole pipeline moves unless the skid is full
    // ---------------------------------------------------------------
    logic pipe_en;
    logic skid_valid_reg, skid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [M_TDATA_W-1:0] skid_data_reg, skid_data_next;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    // ---------------------------------------------------------------
    // Stage 0: angle reduction into [-90, 90] degrees plus flip flag
    // ---------------------------------------------------------------
    logic signed [ANG_W-1:0] ang_in;
    logic signed [AW-1:0]    ang_ext, ang_red, ang_fold;
    logic signed [ZW-1:0]    z_ext;
    logic                    flip_in;
    cordic_vec_t             s0_next, s0_reg;
    logic                    s0_valid_reg;

    always_comb begin
        ang_in  = $signed(s_tdata[48:32]);
        ang_ext = {ang_in[ANG_W-1], ang_in};
        // one wrap is enough over the 17-bit input range
        if (ang_ext > HALF_TURN) begin
            ang_red = ang_ext - FULL_TURN;
        end else if (ang_ext < NEG_HALF_TURN) begin
            ang_red = ang_ext + FULL_TURN;
        end else begin
            ang_red = ang_ext;
        end
        // beyond a quarter turn: rotate by half a turn, negate sin and cos later
        flip_in = 1'b0;
        if (ang_red > QUARTER_TURN) begin
            ang_fold = ang_red - HALF_TURN;
            flip_in  = 1'b1;
        end else if (ang_red < NEG_QUARTER_TURN) begin
            ang_fold = ang_red + HALF_TURN;
            flip_in  = 1'b1;
        end else begin
            ang_fold = ang_red;
        end
        z_ext = {{(ZW-AW){ang_fold[AW-1]}}, ang_fold};

        s0_next.x     = GAIN_Q30;
        s0_next.y     = '0;
        s0_next.z     = z_ext <<< Z_SHIFT;
        s0_next.flip  = flip_in;
        s0_next.cx    = $signed(s_tdata[15:0]);
        s0_next.cy    = $signed(s_tdata[31:16]);
        s0_next.scale = s_tdata[64:49];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_reg <= s0_next;
        end
    end

    // ---------------------------------------------------------------
    // CORDIC: one registered micro-rotation per stage
    // ---------------------------------------------------------------
    cordic_vec_t cvec  [0:N_STAGES];
    logic        cvalid[0:N_STAGES];

    assign cvec[0]   = s0_reg;
    assign cvalid[0] = s0_valid_reg;

    for (genvar gi = 0; gi < N_STAGES; gi++) begin : g_cordic
        rotaff_cordic_stage #(
            .STAGE(gi)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (pipe_en),
            .in_valid (cvalid[gi]),
            .in_vec   (cvec[gi]),
            .out_valid(cvalid[gi+1]),
            .out_vec  (cvec[gi+1])
        );
    end

    // ---------------------------------------------------------------
    // Stage M: scale * cos, scale * sin (x and y fit 32 bits signed)
    // ---------------------------------------------------------------
    cordic_vec_t             cv_end;
    logic signed [TW-1:0]    cos_t, sin_t;
    logic signed [PW-1:0]    pa_next, pb_next, pa_reg, pb_reg;
    logic                    m_flip_reg, m_valid_reg;
    logic signed [CTR_W-1:0] m_cx_reg, m_cy_reg;

    always_comb begin
        cv_end  = cvec[N_STAGES];
        cos_t   = $signed(cv_end.x[TW-1:0]);
        sin_t   = $signed(cv_end.y[TW-1:0]);
        pa_next = $signed({1'b0, cv_end.scale}) * cos_t;
        pb_next = $signed({1'b0, cv_end.scale}) * sin_t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= cvalid[N_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pa_reg     <= pa_next;
            pb_reg     <= pb_next;
            m_flip_reg <= cv_end.flip;
            m_cx_reg   <= cv_end.cx;
            m_cy_reg   <= cv_end.cy;
        end
    end

    // ---------------------------------------------------------------
    // Stage R: round to nearest, ties away from zero; flip applied after
    // rounding since the rounding is symmetric
    // ---------------------------------------------------------------
    function automatic logic signed [CW-1:0] round_coef(input logic signed [PW-1:0] p,
                                                        input logic flip);
        logic [PW-1:0] mag;
        logic [PW-1:0] rnd;
        logic [PW-1:0] res;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        rnd = (mag + RND_HALF) >> RSH;
        res = (p[PW-1] ^ flip) ? PW'(-rnd) : rnd;
        return $signed(res[CW-1:0]);
    endfunction

    logic signed [CW-1:0]    ra_reg, rb_reg;
    logic                    r_valid_reg;
    logic signed [CTR_W-1:0] r_cx_reg, r_cy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            r_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ra_reg   <= round_coef(pa_reg, m_flip_reg);
            rb_reg   <= round_coef(pb_reg, m_flip_reg);
            r_cx_reg <= m_cx_reg;
            r_cy_reg <= m_cy_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage Q: one minus alpha
    // ---------------------------------------------------------------
    logic signed [CW:0]      om_next, om_reg;
    logic signed [CW-1:0]    qa_reg, qb_reg;
    logic                    q_valid_reg;
    logic signed [CTR_W-1:0] q_cx_reg, q_cy_reg;

    assign om_next = COEF_ONE - {ra_reg[CW-1], ra_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            q_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            om_reg   <= om_next;
            qa_reg   <= ra_reg;
            qb_reg   <= rb_reg;
            q_cx_reg <= r_cx_reg;
            q_cy_reg <= r_cy_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage P: four partial products of the offsets
    // ---------------------------------------------------------------
    logic signed [PRW-1:0] omx_reg, omy_reg, bx_reg, by_reg;
    logic signed [CW:0]    qb_ext;
    logic signed [CW-1:0]  pa_coef_reg, pb_coef_reg;
    logic                  p_valid_reg;

    assign qb_ext = {qb_reg[CW-1], qb_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            omx_reg     <= om_reg * q_cx_reg;
            omy_reg     <= om_reg * q_cy_reg;
            bx_reg      <= qb_ext * q_cx_reg;
            by_reg      <= qb_ext * q_cy_reg;
            pa_coef_reg <= qa_reg;
            pb_coef_reg <= qb_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage O: offsets, full width, then fields trimmed to port widths
    // ---------------------------------------------------------------
    logic signed [SUMW-1:0] ox_full, oy_full;
    logic [M_TDATA_W-1:0]   o_data_next, o_data_reg;
    logic                   o_valid_reg;
    logic signed [COEF_W-1:0] alpha_f, beta_f;
    logic signed [OFF_W-1:0]  offx_f, offy_f;

    always_comb begin
        ox_full = SUMW'(omx_reg) - SUMW'(by_reg);
        oy_full = SUMW'(bx_reg) + SUMW'(omy_reg);
        alpha_f = COEF_W'(pa_coef_reg);
        beta_f  = COEF_W'(pb_coef_reg);
        offx_f  = OFF_W'(ox_full);
        offy_f  = OFF_W'(oy_full);
        o_data_next = {{(M_TDATA_W - 2*COEF_W - 2*OFF_W){1'b0}},
                       offy_f, offx_f, beta_f, alpha_f};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            o_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            o_data_reg <= o_data_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register plus skid entry
    // ---------------------------------------------------------------
    logic pop, push;

    assign pop  = out_valid_reg && m_tready;
    assign push = pipe_en && o_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // pipeline frozen; drain skid into the output
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = o_data_reg;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = o_data_reg;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `RAM_ASSERT_NEVER(a_skid_without_out, skid_valid_reg && !out_valid_reg, "skid without output")
    `RAM_ASSERT(a_skid_drains, skid_valid_reg && m_tready |=> !skid_valid_reg, "skid not drained")
    `RAM_ASSERT(a_stall_holds_last, o_valid_reg && skid_valid_reg |=> o_valid_reg, "item lost")

endmodule

`default_nettype wire

// ===== sim/tb_rotation_affine_matrix_core.sv =====
// Self-checking testbench for rotation_affine_matrix_core: random stream traffic,
// bit-exact prediction of the 2x3 matrix (CORDIC, rounding, offsets) per request.
// Depends on rotaff_pkg and the core RTL only.

module tb_rotation_affine_matrix_core;
    import rotaff_pkg::*;

    localparam int CORDIC_STAGES  = 16;
    localparam int COEF_FRAC_BITS = 12;
    localparam int N_STAGES       = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int DRAIN_CYCLES   = N_STAGES + 7 + 20;

    // atan(2^-i) in 2^-24 degree
    localparam longint ARCTAN_STEP [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    // request fields, first field in the low bits
    typedef struct packed {
        logic [SCL_W-1:0]        scale;
        logic signed [ANG_W-1:0] angle;
        logic signed [CTR_W-1:0] cy;
        logic signed [CTR_W-1:0] cx;
    } request_t;

    typedef struct packed {
        logic [OFF_W-1:0]  offset_y;
        logic [OFF_W-1:0]  offset_x;
        logic [COEF_W-1:0] beta;
        logic [COEF_W-1:0] alpha;
    } matrix_t;

    localparam int REQ_W = $bits(request_t);
    localparam int MTX_W = $bits(matrix_t);

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    request_t pending_req_q[$];
    matrix_t  expected_mtx_q[$];
    int       idle_pct = 37;
    int       error_count = 0;

    rotation_affine_matrix_core #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // scale (Q4.12) times trig (Q30) down to Q.F, nearest, ties away from zero
    function automatic longint scale_to_coef(longint s, longint trig);
        longint prod;
        longint mag;
        int     sh;
        sh   = 42 - COEF_FRAC_BITS;
        prod = s * trig;
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
        return (prod < 0) ? -mag : mag;
    endfunction

    function automatic matrix_t rotation_matrix(request_t r);
        longint  cx, cy, ang, s, x, y, z, dx, dy, al, be, unity, ox, oy;
        bit      flip;
        matrix_t m;
        cx   = longint'(r.cx);
        cy   = longint'(r.cy);
        ang  = longint'(r.angle);
        s    = longint'({1'b0, r.scale});
        flip = 1'b0;
        // fold into [-90, 90] degrees, negating both outputs when folded by 180
        ang = ang % 46080;
        if (ang > 23040)  ang -= 46080;
        if (ang < -23040) ang += 46080;
        if (ang > 11520) begin
            ang -= 23040;
            flip = 1'b1;
        end else if (ang < -11520) begin
            ang += 23040;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = ang * 131072;
        for (int i = 0; i < N_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARCTAN_STEP[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARCTAN_STEP[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        al    = scale_to_coef(s, x);
        be    = scale_to_coef(s, y);
        unity = longint'(1) <<< COEF_FRAC_BITS;
        ox    = (unity - al) * cx - be * cy;
        oy    = be * cx + (unity - al) * cy;
        m.alpha    = al[COEF_W-1:0];
        m.beta     = be[COEF_W-1:0];
        m.offset_x = ox[OFF_W-1:0];
        m.offset_y = oy[OFF_W-1:0];
        return m;
    endfunction

    // Driver: presents queued requests, predicts each one on its transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_mtx_q.push_back(rotation_matrix(request_t'(s_tdata[REQ_W-1:0])));
            if (!s_tvalid || s_tready) begin
                if (pending_req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-REQ_W){1'b0}}, pending_req_q.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, compares each result transfer in order.
    always @(posedge aclk) begin
        matrix_t got;
        matrix_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
            if (m_tvalid && m_tready) begin
                got = matrix_t'(m_tdata[MTX_W-1:0]);
                if (expected_mtx_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
                    error_count++;
                end else begin
                    want = expected_mtx_q.pop_front();
                    if (got.alpha !== want.alpha) begin
                        $display("%0t: alpha expected %h actual %h",
                                 $time, want.alpha, got.alpha);
                        error_count++;
                    end
                    if (got.beta !== want.beta) begin
                        $display("%0t: beta expected %h actual %h",
                                 $time, want.beta, got.beta);
                        error_count++;
                    end
                    if (got.offset_x !== want.offset_x) begin
                        $display("%0t: offset_x expected %h actual %h",
                                 $time, want.offset_x, got.offset_x);
                        error_count++;
                    end
                    if (got.offset_y !== want.offset_y) begin
                        $display("%0t: offset_y expected %h actual %h",
                                 $time, want.offset_y, got.offset_y);
                        error_count++;
                    end
                    if (m_tdata[M_TDATA_W-1:MTX_W] !== '0) begin
                        $display("%0t: pad expected 0 actual %h",
                                 $time, m_tdata[M_TDATA_W-1:MTX_W]);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic add_request(int cx, int cy, int ang, int scale);
        request_t r;
        r.cx    = cx[CTR_W-1:0];
        r.cy    = cy[CTR_W-1:0];
        r.angle = ang[ANG_W-1:0];
        r.scale = scale[SCL_W-1:0];
        pending_req_q.push_back(r);
    endtask

    // hold the sender until every queued request has gone and every result is back
    task automatic drain;
        while (pending_req_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_mtx_q.size() != 0)
            @(posedge aclk);
    endtask

    function automatic int rand_center();
        case ($urandom_range(9))
            0:       return -32768;
            1:       return 32767;
            2:       return int'($urandom_range(64)) - 32;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic int rand_angle();
        int a;
        case ($urandom_range(3))
            0: begin
                // near a multiple of 90 degrees, where the folding changes
                a = (int'($urandom_range(8)) - 4) * 11520 + int'($urandom_range(6)) - 3;
                if (a > 46080)  a = 46080;
                if (a < -46080) a = -46080;
            end
            default: a = int'($urandom_range(92160)) - 46080;
        endcase
        return a;
    endfunction

    function automatic int rand_scale();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 65535;
            2:       return 4096 + int'($urandom_range(16)) - 8;
            default: return int'($urandom_range(65535));
        endcase
    endfunction

    task automatic add_random(int count);
        repeat (count)
            add_request(rand_center(), rand_center(), rand_angle(), rand_scale());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, fold boundaries, full turns, zero scale
        add_request(0, 0, 0, 4096);
        add_request(32767, -32768, 0, 4096);
        add_request(-32768, 32767, 46080, 65535);
        add_request(-32768, -32768, -46080, 65535);
        add_request(32767, 32767, 11520, 65535);
        add_request(100, -200, -11520, 4096);
        add_request(1, -1, 11521, 4096);
        add_request(-1, 1, -11521, 4096);
        add_request(500, 600, 23040, 65535);
        add_request(-500, 600, -23040, 1);
        add_request(32767, 32767, 23041, 4096);
        add_request(-32768, -32768, -23041, 65535);
        add_request(1234, -4321, 5760, 0);
        add_request(32767, -32768, -34560, 0);
        add_request(0, 0, 34560, 65535);
        add_request(7, 9, -1, 65535);
        add_request(-7, 9, 1, 2048);
        add_request(32767, 32767, 46079, 65535);
        add_request(-32768, -32768, -46079, 65535);
        add_request(32767, -32768, 11519, 32768);
        add_request(12345, -23456, -11519, 65535);
        drain();

        add_random(400);
        drain();

        // back-to-back stretch: no idling on either side
        idle_pct = 0;
        add_random(300);
        drain();

        idle_pct = 37;
        add_random(400);
        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_mtx_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
